>>> sv/balec_pkg.sv
// ----------------------------------------------------------------------------
// balec_pkg
// Types, constants and codes shared by the bounded array list engine.
// ----------------------------------------------------------------------------
package balec_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int POS_W    = 5;
  localparam int OP_W     = 3;
  localparam int STS_W    = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SORTED = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
  localparam logic [OP_W-1:0] OP_FETCH  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd1;
  localparam logic [STS_W-1:0] STS_INVALID  = 2'd2;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] read_value;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_W-1:0]        entry_count;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LO,
    CELL_TAKE_HI,
    CELL_ZERO
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
    logic     sorted;
    logic     occ;
  } cell_ctl_t;

endpackage

>>> sv/bounded_array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine_unit
// Ordered list of signed entries held in a row of cells, with insert,
// delete, sorted insert, locate, retrieve and clear.
// ----------------------------------------------------------------------------
//   channel   ports                          payload
//   request   in_valid / in_ready / in_data  opcode, value, position
//   result    out_valid/ out_ready/ out_data status, read_value, found_index,
//                                            entry_count
//
// Each request passes through capture, cell compare, then shift and result.
// The cell compare step fills the compare registers in each cell, which feed
// the first-hit chain across the row. One request is in flight at a time; a
// new request is taken while the previous result is still waiting. The update
// waits while the result register holds an untaken transfer. Reset (rst_n,
// synchronous) zeroes all entries and the count.
module bounded_array_list_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  balec_pkg::in_t      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output balec_pkg::out_t     out_data
);

  localparam int CAP = balec_pkg::CAPACITY;

  balec_pkg::state_t                  state_r, state_nxt;
  balec_pkg::in_t                     req_r, req_nxt;
  logic [balec_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic                               out_valid_r, out_valid_nxt;
  balec_pkg::out_t                    out_data_r, out_data_nxt;

  logic                               commit;
  logic                               cmp_en;
  logic                               sorted_mode;
  logic                               ins_ok;
  logic                               del_ok;
  logic                               del_mode;
  logic                               clr_mode;
  logic [balec_pkg::CNT_W-1:0]        ins_at;
  logic [balec_pkg::CNT_W-1:0]        sort_at;
  logic [balec_pkg::IDX_W-1:0]        first_idx;

  balec_pkg::cell_ctl_t               ctl     [CAP];
  logic signed [balec_pkg::VAL_W-1:0] entry_q [CAP];
  logic                               hit     [CAP+1];
  logic                               first_q [CAP];

  assign hit[0] = 1'b0;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    in_ready  = 1'b0;
    cmp_en    = 1'b0;
    commit    = 1'b0;
    case (state_r)
      balec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = balec_pkg::ST_CMP;
        end
      end
      balec_pkg::ST_CMP: begin
        cmp_en    = 1'b1;
        state_nxt = balec_pkg::ST_UPD;
      end
      balec_pkg::ST_UPD: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = balec_pkg::ST_IDLE;
        end
      end
      default: state_nxt = balec_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------ first hit
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAP; i++) begin
      if (first_q[i]) begin
        first_idx = first_idx | balec_pkg::IDX_W'(i);
      end
    end
  end

  assign sort_at     = hit[CAP] ? {1'b0, first_idx} : count_r;
  assign sorted_mode = (req_r.opcode == balec_pkg::OP_SORTED);

  // ---------------------------------------------------------- request eval
  always_comb begin
    ins_ok        = 1'b0;
    del_ok        = 1'b0;
    del_mode      = 1'b0;
    clr_mode      = 1'b0;
    ins_at        = req_r.position;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    out_data_nxt.status      = balec_pkg::STS_OK;
    out_data_nxt.read_value  = '0;
    out_data_nxt.found_index = '0;

    case (req_r.opcode)
      balec_pkg::OP_INSERT: begin
        if (req_r.position > count_r) begin
          out_data_nxt.status = balec_pkg::STS_INVALID;
        end else if (count_r >= balec_pkg::CNT_W'(CAP)) begin
          out_data_nxt.status = balec_pkg::STS_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      balec_pkg::OP_SORTED: begin
        ins_at = sort_at;
        if (count_r >= balec_pkg::CNT_W'(CAP)) begin
          out_data_nxt.status = balec_pkg::STS_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      balec_pkg::OP_DELETE: begin
        del_mode = 1'b1;
        if (req_r.position >= count_r) begin
          out_data_nxt.status = balec_pkg::STS_INVALID;
        end else begin
          del_ok = 1'b1;
        end
      end
      balec_pkg::OP_LOCATE: begin
        if (hit[CAP]) begin
          out_data_nxt.found_index = first_idx;
        end else begin
          out_data_nxt.status = balec_pkg::STS_NOTFOUND;
        end
      end
      balec_pkg::OP_FETCH: begin
        if (req_r.position >= count_r) begin
          out_data_nxt.status = balec_pkg::STS_INVALID;
        end else begin
          out_data_nxt.read_value = entry_q[req_r.position[balec_pkg::IDX_W-1:0]];
        end
      end
      balec_pkg::OP_CLEAR: begin
        clr_mode = 1'b1;
      end
      default: begin
      end
    endcase

    if (ins_ok) begin
      count_nxt                = count_r + 1'b1;
      out_data_nxt.found_index = ins_at[balec_pkg::IDX_W-1:0];
    end
    if (del_ok) begin
      count_nxt = count_r - 1'b1;
    end
    if (clr_mode) begin
      count_nxt = '0;
    end
    out_data_nxt.entry_count = count_nxt;

    if (commit) begin
      out_valid_nxt = 1'b1;
    end else begin
      count_nxt    = count_r;
      out_data_nxt = out_data_r;
    end
  end

  // ------------------------------------------------------------ cell row
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    localparam logic [balec_pkg::CNT_W-1:0] CI = balec_pkg::CNT_W'(g);

    logic signed [balec_pkg::VAL_W-1:0] lo_entry;
    logic signed [balec_pkg::VAL_W-1:0] hi_entry;

    if (g == 0) begin : g_lo_edge
      assign lo_entry = '0;
    end else begin : g_lo
      assign lo_entry = entry_q[g-1];
    end

    if (g == CAP-1) begin : g_hi_edge
      assign hi_entry = '0;
    end else begin : g_hi
      assign hi_entry = entry_q[g+1];
    end

    always_comb begin
      ctl[g].op     = balec_pkg::CELL_HOLD;
      ctl[g].cmp_en = cmp_en;
      ctl[g].sorted = sorted_mode;
      ctl[g].occ    = (CI < count_r);
      if (commit) begin
        if (clr_mode) begin
          ctl[g].op = balec_pkg::CELL_ZERO;
        end else if (ins_ok) begin
          if (CI == ins_at) begin
            ctl[g].op = balec_pkg::CELL_LOAD;
          end else if (CI > ins_at && CI <= count_r) begin
            ctl[g].op = balec_pkg::CELL_TAKE_LO;
          end
        end else if (del_mode && del_ok) begin
          if (CI >= req_r.position && (CI + 1'b1) < count_r) begin
            ctl[g].op = balec_pkg::CELL_TAKE_HI;
          end
        end
      end
    end

    balec_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[g]),
      .value    (req_r.value),
      .lo_entry (lo_entry),
      .hi_entry (hi_entry),
      .hit_in   (hit[g]),
      .hit_out  (hit[g+1]),
      .first    (first_q[g]),
      .entry    (entry_q[g])
    );
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= balec_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/balec_cell.sv
// ----------------------------------------------------------------------------
// balec_cell
// One list slot: holds an entry, compares it with the request value, shifts
// from either neighbour and takes part in the first-hit chain.
// ----------------------------------------------------------------------------
module balec_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  balec_pkg::cell_ctl_t              ctl,
  input  logic signed [balec_pkg::VAL_W-1:0] value,
  input  logic signed [balec_pkg::VAL_W-1:0] lo_entry,
  input  logic signed [balec_pkg::VAL_W-1:0] hi_entry,
  input  logic                              hit_in,
  output logic                              hit_out,
  output logic                              first,
  output logic signed [balec_pkg::VAL_W-1:0] entry
);

  logic signed [balec_pkg::VAL_W-1:0] entry_r, entry_nxt;
  logic                               lt_r, lt_nxt;
  logic                               eq_r, eq_nxt;
  logic                               match;

  always_comb begin
    case (ctl.op)
      balec_pkg::CELL_HOLD:    entry_nxt = entry_r;
      balec_pkg::CELL_LOAD:    entry_nxt = value;
      balec_pkg::CELL_TAKE_LO: entry_nxt = lo_entry;
      balec_pkg::CELL_TAKE_HI: entry_nxt = hi_entry;
      balec_pkg::CELL_ZERO:    entry_nxt = '0;
      default:                 entry_nxt = entry_r;
    endcase
  end

  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (ctl.cmp_en) begin
      lt_nxt = (entry_r < value);
      eq_nxt = (entry_r == value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lt_r <= lt_nxt;
    eq_r <= eq_nxt;
  end

  // sorted insert stops at the first entry not less than the value
  assign match   = ctl.occ & (ctl.sorted ? ~lt_r : eq_r);
  assign first   = match & ~hit_in;
  assign hit_out = hit_in | match;
  assign entry   = entry_r;

endmodule
